FILE: rtl/pid_pkg.sv
package pid_pkg;

  // Q16.16 data path
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int MS_W   = 16;
  localparam int LIM_W  = DATA_W - 1;

  // Full unsigned product of two magnitudes, and the dividend taken from it
  localparam int PROD_W = 2 * DATA_W;
  localparam int DVD_W  = PROD_W - FRAC_W;

  // Divider retires two quotient bits per cycle
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // Stream payload widths (whole bytes)
  localparam int S_TDATA_W = DATA_W + MS_W;
  localparam int SPEED_W   = 7;
  localparam int M_TDATA_W = 5 * DATA_W + SPEED_W + 1;

  // Configuration port
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_SETPOINT = 3'd1,
    CFG_GAIN_P   = 3'd2,
    CFG_GAIN_I   = 3'd3,
    CFG_GAIN_D   = 3'd4,
    CFG_OUT_MIN  = 3'd5,
    CFG_OUT_MAX  = 3'd6,
    CFG_INT_LIM  = 3'd7
  } cfg_idx_t;

  // Fixed constants
  localparam logic [MS_W-1:0]    MS_PER_S  = MS_W'(1000);
  localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(100);

  // Register reset values
  localparam logic signed [DATA_W-1:0] RST_GAIN_P  = DATA_W'(65536);
  localparam logic signed [DATA_W-1:0] RST_GAIN_I  = DATA_W'(6554);
  localparam logic signed [DATA_W-1:0] RST_GAIN_D  = DATA_W'(655);
  localparam logic signed [DATA_W-1:0] RST_OUT_MIN = -DATA_W'(6553600);
  localparam logic signed [DATA_W-1:0] RST_OUT_MAX = DATA_W'(6553600);
  localparam logic [LIM_W-1:0]         RST_INT_LIM = LIM_W'(6553600);

  typedef logic signed [DATA_W-1:0] q_t;

  // Sequencer to shared multiply/divide unit
  typedef struct packed {
    logic              mul_go;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic              div_go;
    logic [MS_W-1:0]   div_den;
  } mdu_req_t;

  // Shared unit back to sequencer
  typedef struct packed {
    logic              div_done;
    logic [PROD_W-1:0] prod;
    logic [DVD_W-1:0]  quo;
  } mdu_rsp_t;

endpackage

FILE: rtl/pid_mdu.sv
module pid_mdu
  import pid_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mdu_req_t req,
  output mdu_rsp_t rsp
);

  logic [PROD_W-1:0] prod;
  logic [DVD_W-1:0]  dq;
  logic [MS_W-1:0]   rem;
  logic [MS_W-1:0]   den;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [MS_W:0]     r1;
  logic [MS_W:0]     r2;
  logic              b1;
  logic              b2;
  logic [DVD_W-1:0]  dq_next;
  logic [MS_W-1:0]   rem_next;

  // Unsigned magnitude multiplier, registered
  always_ff @(posedge clk) begin
    if (req.mul_go) begin
      prod <= PROD_W'(req.mul_a) * PROD_W'(req.mul_b);
    end
  end

  // Two restoring divide steps per cycle
  always_comb begin
    r1 = {rem, dq[DVD_W-1]};
    b1 = (r1 >= {1'b0, den});
    if (b1) begin
      r1 = r1 - {1'b0, den};
    end
    r2 = {r1[MS_W-1:0], dq[DVD_W-2]};
    b2 = (r2 >= {1'b0, den});
    if (b2) begin
      r2 = r2 - {1'b0, den};
    end
    dq_next  = {dq[DVD_W-3:0], b1, b2};
    rem_next = r2[MS_W-1:0];
  end

  // Divider control: dividend is the low part of the held integer product
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.div_go) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Integer product (no binary point shift); it always fits the dividend
  always_ff @(posedge clk) begin
    if (req.div_go) begin
      dq  <= prod[DVD_W-1:0];
      rem <= '0;
      den <= req.div_den;
    end else if (busy) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  assign rsp.div_done = done;
  assign rsp.prod     = prod;
  assign rsp.quo      = dq;

`ifndef NO_ASSERTIONS
  a_div_go_idle: assert property (@(posedge clk) disable iff (rst)
    req.div_go |-> !busy)
    else $error("divide started while divider busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divide done held for more than one cycle");
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0))
    else $error("divider busy with no steps left");
`endif

endmodule

FILE: rtl/pid_controller_step.sv
// PID controller step, signed Q16.16, integral clamp anti-windup.
// Input stream s_*: one item per measurement (sample and elapsed_ms).
// Output stream m_*: one result item per input item, in order.
// Configuration channel cfg_*: register index and data, taken only while
// the sequencer is idle; writing enable = 1 clears the accumulator and
// the previous error. A pending configuration write holds off the input.
// When enabled, an item runs the error, proportional, integral and
// derivative steps, the derivative divide being skipped when elapsed_ms
// is zero; when disabled it goes straight to the result (all-zero
// result, state held). One item is in work at a time, so a new item is
// taken only once the last one has left the sequencer. The shared
// multiply/divide unit does one 32x32 multiply per cycle; its divider
// retires two quotient bits a cycle and divides by 1000 and by elapsed_ms.
// The result sits in an output register; a new item is accepted while it
// waits, but a finished item waits in the sequencer until that register
// frees up, so a stalled receiver eventually stalls the input.
// Reset (synchronous, rst high) restores the default registers, clears
// the accumulator and previous error, and empties the output register.
module pid_controller_step
  import pid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // sample [31:0], elapsed_ms [47:32]
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // control_out [31:0], error_out [63:32], p_term [95:64], i_term [127:96],
  // d_term [159:128], drive_speed [166:160], drive_reverse [167]
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_ERR   = 16'b0000_0000_0000_0010,
    S_MULP  = 16'b0000_0000_0000_0100,
    S_FINP  = 16'b0000_0000_0000_1000,
    S_MULN  = 16'b0000_0000_0001_0000,
    S_DIVN  = 16'b0000_0000_0010_0000,
    S_WAITN = 16'b0000_0000_0100_0000,
    S_ACC   = 16'b0000_0000_1000_0000,
    S_MULI  = 16'b0000_0001_0000_0000,
    S_FINI  = 16'b0000_0010_0000_0000,
    S_MULD  = 16'b0000_0100_0000_0000,
    S_FIND  = 16'b0000_1000_0000_0000,
    S_MULK  = 16'b0001_0000_0000_0000,
    S_DIVK  = 16'b0010_0000_0000_0000,
    S_WAITK = 16'b0100_0000_0000_0000,
    S_SUM   = 16'b1000_0000_0000_0000
  } state_t;

  localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Saturate a 33-bit signed value
  function automatic q_t sat1(input logic signed [DATA_W:0] x);
    if (x[DATA_W] != x[DATA_W-1]) begin
      return x[DATA_W] ? Q_MIN : Q_MAX;
    end
    return x[DATA_W-1:0];
  endfunction

  // Saturate a 34-bit signed value
  function automatic q_t sat2(input logic signed [DATA_W+1:0] x);
    if ((x[DATA_W+1] != x[DATA_W]) || (x[DATA_W] != x[DATA_W-1])) begin
      return x[DATA_W+1] ? Q_MIN : Q_MAX;
    end
    return x[DATA_W-1:0];
  endfunction

  // Apply a sign to a magnitude and saturate
  function automatic q_t sat_mag(input logic [DVD_W-1:0] mag, input logic neg);
    if (mag[DVD_W-1:DATA_W-1] != '0) begin
      return neg ? Q_MIN : Q_MAX;
    end
    return neg ? -q_t'(mag[DATA_W-1:0]) : q_t'(mag[DATA_W-1:0]);
  endfunction

  function automatic logic [DATA_W-1:0] mag_of(input q_t x);
    return x[DATA_W-1] ? -x : x;
  endfunction

  state_t   state;
  state_t   state_next;
  mdu_req_t req;
  mdu_rsp_t rsp;

  // Configuration registers
  logic             enable;
  q_t               setpoint;
  q_t               gain_p;
  q_t               gain_i;
  q_t               gain_d;
  q_t               out_min;
  q_t               out_max;
  logic [LIM_W-1:0] integral_limit;

  // Controller state
  q_t integral_acc;
  q_t last_error;

  // Per-item working registers
  q_t              sample;
  logic [MS_W-1:0] ms;
  logic            zero_res;
  logic            neg;
  q_t              err;
  q_t              derr;
  q_t              p_val;
  q_t              i_val;
  q_t              m_val;
  q_t              d_val;

  // Output register
  q_t               o_ctl;
  q_t               o_err;
  q_t               o_p;
  q_t               o_i;
  q_t               o_d;
  logic [SPEED_W-1:0] o_speed;
  logic             o_rev;

  logic             s_take;
  logic             out_free;
  q_t               inc;
  q_t               acc_sum;
  q_t               lim_pos;
  q_t               lim_neg;
  q_t               u_sat;
  q_t               u_clamp;
  logic [DATA_W-1:0] u_mag;
  logic [SPEED_W-1:0] speed;

  // Configuration has priority over a new item in the idle state
  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign s_take    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  pid_mdu u_mdu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Sequencer and unit operand selection
  always_comb begin
    state_next  = state;
    req.mul_go  = 1'b0;
    req.mul_a   = '0;
    req.mul_b   = '0;
    req.div_go  = 1'b0;
    req.div_den = MS_PER_S;
    case (state)
      S_IDLE: begin
        if (s_take) begin
          state_next = enable ? S_ERR : S_SUM;
        end
      end
      S_ERR: state_next = S_MULP;
      S_MULP: begin
        req.mul_go = 1'b1;
        req.mul_a  = mag_of(gain_p);
        req.mul_b  = mag_of(err);
        state_next = S_FINP;
      end
      S_FINP: state_next = S_MULN;
      S_MULN: begin
        req.mul_go = 1'b1;
        req.mul_a  = mag_of(err);
        req.mul_b  = DATA_W'(ms);
        state_next = S_DIVN;
      end
      S_DIVN: begin
        req.div_go = 1'b1;
        state_next = S_WAITN;
      end
      S_WAITN: begin
        if (rsp.div_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC: state_next = S_MULI;
      S_MULI: begin
        req.mul_go = 1'b1;
        req.mul_a  = mag_of(gain_i);
        req.mul_b  = mag_of(integral_acc);
        state_next = S_FINI;
      end
      S_FINI: state_next = S_MULD;
      S_MULD: begin
        req.mul_go = 1'b1;
        req.mul_a  = mag_of(gain_d);
        req.mul_b  = mag_of(derr);
        state_next = S_FIND;
      end
      S_FIND: state_next = (ms == '0) ? S_SUM : S_MULK;
      S_MULK: begin
        req.mul_go = 1'b1;
        req.mul_a  = mag_of(m_val);
        req.mul_b  = DATA_W'(MS_PER_S);
        state_next = S_DIVK;
      end
      S_DIVK: begin
        req.div_go  = 1'b1;
        req.div_den = ms;
        state_next  = S_WAITK;
      end
      S_WAITK: begin
        req.div_den = ms;
        if (rsp.div_done) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accumulator update with symmetric clamp
  always_comb begin
    inc     = sat_mag(rsp.quo, neg);
    acc_sum = sat1({integral_acc[DATA_W-1], integral_acc} + {inc[DATA_W-1], inc});
    lim_pos = q_t'({1'b0, integral_limit});
    lim_neg = -lim_pos;
    if (acc_sum > lim_pos) begin
      acc_sum = lim_pos;
    end else if (acc_sum < lim_neg) begin
      acc_sum = lim_neg;
    end
  end

  // Output sum, clamp and drive
  always_comb begin
    u_sat = sat2({{2{p_val[DATA_W-1]}}, p_val} + {{2{i_val[DATA_W-1]}}, i_val}
                 + {{2{d_val[DATA_W-1]}}, d_val});
    if (u_sat > out_max) begin
      u_clamp = out_max;
    end else if (u_sat < out_min) begin
      u_clamp = out_min;
    end else begin
      u_clamp = u_sat;
    end
    u_mag = mag_of(u_clamp);
    if (u_mag[DATA_W-1:FRAC_W] > (DATA_W-FRAC_W)'(SPEED_MAX)) begin
      speed = SPEED_MAX;
    end else begin
      speed = u_mag[FRAC_W+SPEED_W-1:FRAC_W];
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_take) begin
          sample   <= s_tdata[DATA_W-1:0];
          ms       <= s_tdata[S_TDATA_W-1:DATA_W];
          zero_res <= !enable;
        end
      end
      S_ERR: err <= sat1({setpoint[DATA_W-1], setpoint} - {sample[DATA_W-1], sample});
      S_MULP: begin
        neg  <= gain_p[DATA_W-1] ^ err[DATA_W-1];
        derr <= sat1({err[DATA_W-1], err} - {last_error[DATA_W-1], last_error});
      end
      S_FINP: p_val <= sat_mag(rsp.prod[PROD_W-1:FRAC_W], neg);
      S_MULN: neg <= err[DATA_W-1];
      S_MULI: neg <= gain_i[DATA_W-1] ^ integral_acc[DATA_W-1];
      S_FINI: i_val <= sat_mag(rsp.prod[PROD_W-1:FRAC_W], neg);
      S_MULD: neg <= gain_d[DATA_W-1] ^ derr[DATA_W-1];
      S_FIND: begin
        m_val <= sat_mag(rsp.prod[PROD_W-1:FRAC_W], neg);
        d_val <= '0;
      end
      S_MULK: neg <= m_val[DATA_W-1];
      S_WAITK: begin
        if (rsp.div_done) begin
          d_val <= sat_mag(rsp.quo, neg);
        end
      end
      default: ;
    endcase
  end

  // Configuration registers and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      setpoint       <= '0;
      gain_p         <= RST_GAIN_P;
      gain_i         <= RST_GAIN_I;
      gain_d         <= RST_GAIN_D;
      out_min        <= RST_OUT_MIN;
      out_max        <= RST_OUT_MAX;
      integral_limit <= RST_INT_LIM;
      integral_acc   <= '0;
      last_error     <= '0;
    end else begin
      if (state == S_ACC) begin
        integral_acc <= acc_sum;
      end
      if ((state == S_SUM) && out_free && !zero_res) begin
        last_error <= err;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENABLE: begin
            enable <= cfg_data[0];
            if (cfg_data[0]) begin
              integral_acc <= '0;
              last_error   <= '0;
            end
          end
          CFG_SETPOINT: setpoint       <= cfg_data;
          CFG_GAIN_P:   gain_p         <= cfg_data;
          CFG_GAIN_I:   gain_i         <= cfg_data;
          CFG_GAIN_D:   gain_d         <= cfg_data;
          CFG_OUT_MIN:  out_min        <= cfg_data;
          CFG_OUT_MAX:  out_max        <= cfg_data;
          CFG_INT_LIM:  integral_limit <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_SUM) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SUM) && out_free) begin
      if (zero_res) begin
        o_ctl   <= '0;
        o_err   <= '0;
        o_p     <= '0;
        o_i     <= '0;
        o_d     <= '0;
        o_speed <= '0;
        o_rev   <= 1'b0;
      end else begin
        o_ctl   <= u_clamp;
        o_err   <= err;
        o_p     <= p_val;
        o_i     <= i_val;
        o_d     <= d_val;
        o_speed <= speed;
        o_rev   <= u_clamp[DATA_W-1];
      end
    end
  end

  assign m_tdata = {o_rev, o_speed, o_d, o_i, o_p, o_err, o_ctl};

`ifndef NO_ASSERTIONS
  a_acc_in_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |=> ((integral_acc <= q_t'({1'b0, integral_limit})) &&
                          (integral_acc >= -q_t'({1'b0, integral_limit}))))
    else $error("integral accumulator outside its limit");
  a_no_zero_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAITK) |-> (ms != '0))
    else $error("derivative divide with zero elapsed time");
  a_speed_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_speed <= SPEED_MAX))
    else $error("drive speed above cap");
  a_rev_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_rev == o_ctl[DATA_W-1]))
    else $error("direction bit disagrees with output sign");
`endif

endmodule

FILE: bench/pid_step_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, sample and result channels of the PID step block.
// Keeps its own copy of the registers and loop state, predicts each result
// from the accepted item and compares it field by field with the block's output.
module pid_step_checker
  import pid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint unsigned QCAP = 64'd1 << 31;
  localparam int REPORT_LIMIT = 10;

  // Result item, top bit first so it overlays m_tdata directly
  typedef struct packed {
    logic        drive_reverse;
    logic [6:0]  drive_speed;
    logic [31:0] d_term;
    logic [31:0] i_term;
    logic [31:0] p_term;
    logic [31:0] error_out;
    logic [31:0] control_out;
  } pid_result_t;

  // Register copy and loop state
  logic   ctl_on;
  longint target, kp, ki, kd, lim_lo, lim_hi, acc_lim;
  longint acc, prev_err;

  pid_result_t pending_outputs[$];
  int          fails = 0;

  function automatic longint sat_q(longint x);
    if (x > QMAX) return QMAX;
    if (x < QMIN) return QMIN;
    return x;
  endfunction

  // Q16.16 product: magnitude truncated, then saturated
  function automatic longint q_mul(longint a, longint b);
    longint unsigned ma, mb, mag;
    logic            neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    mag = (ma * mb) >> FRAC_W;
    if (mag >= QCAP) return neg ? QMIN : QMAX;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic void restore_defaults();
    ctl_on   = 1'b0;
    target   = 0;
    kp       = 65536;
    ki       = 6554;
    kd       = 655;
    lim_lo   = -6553600;
    lim_hi   = 6553600;
    acc_lim  = 6553600;
    acc      = 0;
    prev_err = 0;
  endfunction

  function automatic void load_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    case (idx)
      CFG_ENABLE: begin
        ctl_on = val[0];
        // enabling restarts the loop
        if (val[0]) begin
          acc      = 0;
          prev_err = 0;
        end
      end
      CFG_SETPOINT: target  = longint'($signed(val));
      CFG_GAIN_P:   kp      = longint'($signed(val));
      CFG_GAIN_I:   ki      = longint'($signed(val));
      CFG_GAIN_D:   kd      = longint'($signed(val));
      CFG_OUT_MIN:  lim_lo  = longint'($signed(val));
      CFG_OUT_MAX:  lim_hi  = longint'($signed(val));
      CFG_INT_LIM:  acc_lim = longint'(val[LIM_W-1:0]);
      default: ;
    endcase
  endfunction

  // One controller step; when enabled, advances the accumulator and previous error
  function automatic pid_result_t step_controller(logic [S_TDATA_W-1:0] item);
    longint      smp, ms, err, p, i, dv, u, mag;
    pid_result_t r;
    smp = longint'($signed(item[31:0]));
    ms  = longint'(item[47:32]);
    r   = '0;
    if (!ctl_on) return r;

    err = sat_q(target - smp);
    p   = q_mul(kp, err);
    acc = sat_q(acc + sat_q(err * ms / 1000));
    if (acc > acc_lim) acc = acc_lim;
    else if (acc < -acc_lim) acc = -acc_lim;
    i = q_mul(ki, acc);
    // no derivative on a zero interval
    if (ms == 0) dv = 0;
    else dv = sat_q(q_mul(kd, sat_q(err - prev_err)) * 1000 / ms);
    // upper clamp tested first, which matters for inverted limits
    u = sat_q(p + i + dv);
    if (u > lim_hi) u = lim_hi;
    else if (u < lim_lo) u = lim_lo;
    prev_err = err;

    mag = ((u < 0) ? -u : u) >>> FRAC_W;
    if (mag > 100) mag = 100;

    r.control_out   = u[31:0];
    r.error_out     = err[31:0];
    r.p_term        = p[31:0];
    r.i_term        = i[31:0];
    r.d_term        = dv[31:0];
    r.drive_speed   = mag[6:0];
    r.drive_reverse = (u < 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= REPORT_LIMIT)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Results are handled before new items so an item never meets its own result
  always @(posedge clk) begin
    pid_result_t want, got;
    if (rst) begin
      restore_defaults();
      pending_outputs.delete();
    end else begin
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
      if (m_tvalid && m_tready) begin
        got = pid_result_t'(m_tdata);
        if (pending_outputs.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("result with no item pending: %h", m_tdata);
        end else begin
          want = pending_outputs.pop_front();
          check_field("control_out", want.control_out, got.control_out);
          check_field("error_out", want.error_out, got.error_out);
          check_field("p_term", want.p_term, got.p_term);
          check_field("i_term", want.i_term, got.i_term);
          check_field("d_term", want.d_term, got.d_term);
          check_field("drive_speed", 32'(want.drive_speed), 32'(got.drive_speed));
          check_field("drive_reverse", 32'(want.drive_reverse), 32'(got.drive_reverse));
        end
      end
      if (s_tvalid && s_tready) pending_outputs.push_back(step_controller(s_tdata));
    end
    outstanding <= pending_outputs.size();
    fail_count  <= fails;
  end

endmodule

FILE: bench/pid_controller_step_tb.sv
`timescale 1ns / 1ps

module pid_controller_step_tb;
  import pid_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int SEGMENTS     = 7;
  localparam int SEG_ITEMS    = 95;

  typedef struct {
    logic        en;
    logic [31:0] setpoint;
    logic [31:0] kp;
    logic [31:0] ki;
    logic [31:0] kd;
    logic [31:0] out_min;
    logic [31:0] out_max;
    logic [30:0] int_lim;
  } pid_settings_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLE;
  logic [DATA_W-1:0]    cfg_data = '0;

  int          fail_count;
  int          outstanding;
  int          tx_idle_pct = 30;
  int          rx_idle_pct = 64;
  int unsigned cycles = 0;

  pid_controller_step DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pid_step_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic cfg_write(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Enable goes last; unused upper bits carry noise
  task automatic apply_settings(pid_settings_t st);
    cfg_write(CFG_SETPOINT, st.setpoint);
    cfg_write(CFG_GAIN_P, st.kp);
    cfg_write(CFG_GAIN_I, st.ki);
    cfg_write(CFG_GAIN_D, st.kd);
    cfg_write(CFG_OUT_MIN, st.out_min);
    cfg_write(CFG_OUT_MAX, st.out_max);
    cfg_write(CFG_INT_LIM, {1'($urandom_range(1)), st.int_lim});
    cfg_write(CFG_ENABLE, {31'($urandom()), st.en});
    cfg_valid <= 1'b0;
  endtask

  // Sender idles at random before the item; tvalid stays high after acceptance
  task automatic send_item(logic [31:0] smp, logic [15:0] ms);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ms, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Wait for every result, then let the sequencer settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pid_settings_t default_settings();
    pid_settings_t st;
    st.en       = 1'b1;
    st.setpoint = '0;
    st.kp       = 32'd65536;
    st.ki       = 32'd6554;
    st.kd       = 32'd655;
    st.out_min  = -32'd6553600;
    st.out_max  = 32'd6553600;
    st.int_lim  = 31'd6553600;
    return st;
  endfunction

  // Mostly near zero, sometimes extreme or fully random
  function automatic logic [31:0] pick_word(int unsigned spread);
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return $urandom_range(2 * spread) - spread;
    endcase
  endfunction

  function automatic pid_settings_t random_settings();
    pid_settings_t st;
    logic [31:0]   a;
    st.en       = ($urandom_range(9) != 0);
    st.setpoint = pick_word(50 << 16);
    st.kp       = pick_word(4 << 16);
    st.ki       = pick_word(4 << 16);
    st.kd       = pick_word(1 << 16);
    case ($urandom_range(9))
      0: begin
        st.out_min = 32'h8000_0000;
        st.out_max = 32'h7FFF_FFFF;
      end
      1: begin
        st.out_min = $urandom();
        st.out_max = $urandom();
      end
      2: begin
        // inverted limits
        a          = $urandom_range(100 << 16);
        st.out_min = a;
        st.out_max = -a;
      end
      default: begin
        st.out_max = $urandom_range(1 << 16, 120 << 16);
        st.out_min = -32'($urandom_range(1 << 16, 120 << 16));
      end
    endcase
    case ($urandom_range(9))
      0:       st.int_lim = '0;
      1:       st.int_lim = 31'h7FFF_FFFF;
      2:       st.int_lim = 31'($urandom());
      default: st.int_lim = 31'($urandom_range(200 << 16));
    endcase
    return st;
  endfunction

  // Measurements mostly close to the target so the loop stays out of saturation
  function automatic logic [31:0] pick_sample(logic [31:0] target);
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3:    return target + $urandom_range(80 << 16) - (40 << 16);
      default: return target + $urandom_range(2 << 16) - (1 << 16);
    endcase
  endfunction

  function automatic logic [15:0] pick_ms();
    case ($urandom_range(19))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(1, 100));
    endcase
  endfunction

  initial begin
    pid_settings_t st;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Disabled out of reset: all-zero results
    send_item(32'h7FFF_FFFF, 16'hFFFF);
    send_item(32'h1234_5678, 16'd10);

    // Default gains, sample and interval extremes, zero interval
    drain();
    st = default_settings();
    apply_settings(st);
    send_item(32'h0000_0000, 16'd1000);
    send_item(32'h7FFF_FFFF, 16'hFFFF);
    send_item(32'h8000_0000, 16'hFFFF);
    send_item(32'h8000_0000, 16'd0);
    send_item(32'(100 << 16), 16'd10);
    send_item(-32'(200 << 16), 16'd1);
    send_item(32'h0000_0000, 16'd0);

    // Inverted output limits, proportional only
    drain();
    st.kp      = 32'(2 << 16);
    st.ki      = '0;
    st.kd      = '0;
    st.out_min = 32'(50 << 16);
    st.out_max = -32'(50 << 16);
    st.int_lim = '0;
    apply_settings(st);
    send_item(-32'(10 << 16), 16'd5);
    send_item(32'(100 << 16), 16'd5);
    send_item(32'h0000_0000, 16'd0);

    // Register extremes
    drain();
    st.setpoint = 32'h7FFF_FFFF;
    st.kp       = 32'h8000_0000;
    st.ki       = 32'h7FFF_FFFF;
    st.kd       = 32'h8000_0000;
    st.out_min  = 32'h8000_0000;
    st.out_max  = 32'h7FFF_FFFF;
    st.int_lim  = 31'h7FFF_FFFF;
    apply_settings(st);
    send_item(32'h8000_0000, 16'd1);
    send_item(32'h7FFF_FFFF, 16'hFFFF);
    send_item(32'h0000_0000, 16'd1);
    send_item(32'h8000_0000, 16'd0);

    // Disabled again
    drain();
    st.en = 1'b0;
    apply_settings(st);
    send_item(32'h8000_0000, 16'd7);
    send_item(32'h0000_FFFF, 16'd0);

    // Random settings per segment under three idling regimes
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 64 : 0;
      rx_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 30 : 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        drain();
        st = random_settings();
        apply_settings(st);
        repeat (SEG_ITEMS) send_item(pick_sample(st.setpoint), pick_ms());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pid_pkg.sv
rtl/pid_mdu.sv
rtl/pid_controller_step.sv
bench/pid_step_checker.sv
bench/pid_controller_step_tb.sv
